### hdl/bpfa_pkg.sv
// Shared constants, field widths and codes of the bitmap page-frame allocator.
// No dependencies; every other file of the block but bpfa_map_ram uses this package.
`default_nettype none

package bpfa_pkg;

  // Field widths of the request and response items
  localparam int ADDR_W  = 32;
  localparam int LIMIT_W = 17;

  // Frame geometry: 4 KB frames
  localparam int FRAME_BYTES = 4096;
  localparam int FRAME_SHIFT = 12;

  // Width that holds a 33-bit byte sum shifted down to frames, plus a spare bit
  localparam int EXT_W = 22;

  // Default geometry of the used map
  localparam int NUM_FRAMES_DEF    = 65536;
  localparam int MAP_WORD_BITS_DEF = 32;

  // frame_limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESERVE = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

endpackage

`default_nettype wire

### hdl/bpfa_if.sv
// Request and response channel interfaces of the page-frame allocator.
// Depends on bpfa_pkg for the field widths.
`default_nettype none

interface bpfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [bpfa_pkg::ADDR_W-1:0] phys_address;
  logic [bpfa_pkg::ADDR_W-1:0] range_bytes;

  modport source (output valid, action, phys_address, range_bytes, input ready);
  modport sink   (input valid, action, phys_address, range_bytes, output ready);
endinterface

interface bpfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bpfa_pkg::ADDR_W-1:0]  frame_address;
  logic [1:0]                   status;
  logic [bpfa_pkg::LIMIT_W-1:0] free_frames;

  modport source (output valid, frame_address, status, free_frames, input ready);
  modport sink   (input valid, frame_address, status, free_frames, output ready);
endinterface

`default_nettype wire

### hdl/bpfa_map_ram.sv
// Used-map storage: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module bpfa_map_ram #(
  parameter int WB    = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [WB-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [WB-1:0] rdata_o
);

  logic [WB-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/bpfa_word_unit.sv
// Shared word unit: range mask, lowest-candidate search, bit count and merge of one map word.
// Depends on bpfa_pkg for the action codes.
`default_nettype none

module bpfa_word_unit #(
  parameter int WB  = 32,
  parameter int FRW = 17,
  parameter int BW  = 18
) (
  input  wire bpfa_pkg::action_e         op_i,
  input  wire logic [WB-1:0]             word_i,
  input  wire logic [BW-1:0]             base_i,
  input  wire logic [FRW-1:0]            lo_i,
  input  wire logic [FRW-1:0]            hi_i,
  output logic      [WB-1:0]             word_o,
  output logic                           hit_o,
  output logic      [$clog2(WB)-1:0]     idx_o,
  output logic      [$clog2(WB+1)-1:0]   pop_o,
  output logic                           last_o
);

  import bpfa_pkg::*;

  localparam int IW   = $clog2(WB);
  localparam int CNTW = $clog2(WB + 1);
  localparam logic [BW-1:0] WB_B = BW'(WB);

  logic [BW-1:0] lo_b, hi_b, lo_off, hi_off;
  logic [WB-1:0] mask_lo, mask_hi, mask, cand, lowest;

  assign lo_b   = BW'(lo_i);
  assign hi_b   = BW'(hi_i);
  assign lo_off = lo_b - base_i;
  assign hi_off = hi_b - base_i;

  // bits of this word whose frame lies in [lo, hi)
  always_comb begin
    if (lo_b <= base_i) begin
      mask_lo = '1;
    end else if (lo_off >= WB_B) begin
      mask_lo = '0;
    end else begin
      mask_lo = {WB{1'b1}} << lo_off[IW-1:0];
    end
    if (hi_b <= base_i) begin
      mask_hi = '0;
    end else if (hi_off >= WB_B) begin
      mask_hi = '1;
    end else begin
      mask_hi = ~({WB{1'b1}} << hi_off[IW-1:0]);
    end
    mask = mask_lo & mask_hi;
  end

  // candidates: free bits for alloc and reserve, used bits for free and release
  always_comb begin
    case (op_i)
      ACT_ALLOC, ACT_RESERVE: cand = ~word_i & mask;
      default:                cand = word_i & mask;
    endcase
  end

  assign lowest = cand & (~cand + WB'(1));
  assign hit_o  = |cand;
  assign pop_o  = CNTW'($countones(cand));
  assign last_o = (base_i + WB_B) >= hi_b;

  // one-hot to index
  always_comb begin
    idx_o = '0;
    for (int i = 0; i < WB; i++) begin
      if (lowest[i]) begin
        idx_o = idx_o | IW'(i);
      end
    end
  end

  // updated word
  always_comb begin
    case (op_i)
      ACT_ALLOC:   word_o = word_i | lowest;
      ACT_RESERVE: word_o = word_i | mask;
      default:     word_o = word_i & ~mask;
    endcase
  end

endmodule

`default_nettype wire

### hdl/bpfa_ctrl.sv
// Sequencer of the allocator: decodes an item, walks the used map one word a cycle
// through the shared word unit and keeps the free count, hint and result register.
// Depends on bpfa_pkg, bpfa_if and bpfa_word_unit.
`default_nettype none

module bpfa_ctrl #(
  parameter int NUM_FRAMES    = 65536,
  parameter int MAP_WORD_BITS = 32,
  parameter int MAP_WORDS     = 2048,
  parameter int MAW           = 11
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [bpfa_pkg::LIMIT_W-1:0] limit_i,
  bpfa_req_if.sink                          req_i,
  bpfa_rsp_if.source                        rsp_o,
  output logic                              mem_we_o,
  output logic      [MAW-1:0]               mem_waddr_o,
  output logic      [MAP_WORD_BITS-1:0]     mem_wdata_o,
  output logic      [MAW-1:0]               mem_raddr_o,
  input  wire logic [MAP_WORD_BITS-1:0]     mem_rdata_i
);

  import bpfa_pkg::*;

  localparam int WB   = MAP_WORD_BITS;
  localparam int IW   = $clog2(WB);
  localparam int CNTW = $clog2(WB + 1);
  localparam int FRW  = $clog2(NUM_FRAMES + 1);
  localparam int BW   = FRW + 1;
  // frame-to-word reciprocal, exact for every frame index below 2**FRW
  localparam int K    = FRW + IW;
  localparam int RW   = K + 1;
  localparam int PW   = FRW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << K) + 64'(WB) - 64'd1) / 64'(WB));
  localparam logic [BW-1:0]    WB_B      = BW'(WB);
  localparam logic [MAW-1:0]   LAST_WORD = MAW'(MAP_WORDS - 1);
  localparam logic [EXT_W-1:0] NF_EXT    = EXT_W'(NUM_FRAMES);
  localparam logic [FRW-1:0]   NF_FRW    = FRW'(NUM_FRAMES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_BASE,
    S_EX,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [MAW-1:0]      clr_q;
  logic [MAW-1:0]      cur_word_q;
  logic [BW-1:0]       base_q;
  logic [FRW-1:0]      lo_q, hi_q, lim_q, hint_q, cnt_q;
  logic [PW-1:0]       prod_q;
  logic                phase2_q;
  action_e             act_q;
  logic [ADDR_W-1:0]   start_q, len_q;
  logic [ADDR_W-1:0]   res_addr_q;
  status_e             res_status_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  status_e             out_status_q;
  logic [LIMIT_W-1:0]  out_free_q;
  logic                out_load;

  // decode arithmetic
  logic [FRW-1:0]      lim_c;
  logic [EXT_W-1:0]    lim_ext, s_frame, res_end, res_fe, rel_start, rel_end, rel_fe;
  logic [ADDR_W:0]     sum_len;
  logic [MAW-1:0]      w_c;

  // word unit
  logic [WB-1:0]       new_word;
  logic                hit, last;
  logic [IW-1:0]       idx;
  logic [CNTW-1:0]     pop;
  logic [BW-1:0]       fr_found, fr_next;

  bpfa_word_unit #(
    .WB  (WB),
    .FRW (FRW),
    .BW  (BW)
  ) u_word_unit (
    .op_i   (act_q),
    .word_i (mem_rdata_i),
    .base_i (base_q),
    .lo_i   (lo_q),
    .hi_i   (hi_q),
    .word_o (new_word),
    .hit_o  (hit),
    .idx_o  (idx),
    .pop_o  (pop),
    .last_o (last)
  );

  // effective limit and range bounds in frames
  always_comb begin
    if (EXT_W'(limit_i) >= NF_EXT) begin
      lim_c = NF_FRW;
    end else begin
      lim_c = FRW'(limit_i);
    end
    lim_ext   = EXT_W'(lim_c);
    sum_len   = {1'b0, start_q} + {1'b0, len_q};
    s_frame   = EXT_W'(start_q >> FRAME_SHIFT);
    res_end   = EXT_W'(((ADDR_W + 2)'(sum_len) + (ADDR_W + 2)'(FRAME_BYTES - 1))
                       >> FRAME_SHIFT);
    res_fe    = (res_end > NF_EXT) ? NF_EXT : res_end;
    rel_start = EXT_W'(((ADDR_W + 1)'(start_q) + (ADDR_W + 1)'(FRAME_BYTES - 1))
                       >> FRAME_SHIFT);
    rel_end   = EXT_W'(sum_len >> FRAME_SHIFT);
    rel_fe    = (rel_end > lim_ext) ? lim_ext : rel_end;
  end

  assign w_c      = prod_q[K +: MAW];
  assign fr_found = base_q + BW'(idx);
  assign fr_next  = fr_found + BW'(1);

  // result moves into the output register this cycle
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // map port control
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_word_q;
    mem_wdata_o = new_word;
    mem_raddr_o = cur_word_q + MAW'(1);
    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '1;
      end
      S_BASE: begin
        mem_raddr_o = w_c;
      end
      S_EX: begin
        if (act_q == ACT_ALLOC || act_q == ACT_FREE) begin
          mem_we_o = hit;
        end else begin
          mem_we_o = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.frame_address = out_addr_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.free_frames   = out_free_q;

  // sequencer, allocator state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cur_word_q   <= '0;
      base_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      lim_q        <= '0;
      hint_q       <= '0;
      cnt_q        <= '0;
      prod_q       <= '0;
      phase2_q     <= 1'b0;
      act_q        <= ACT_ALLOC;
      start_q      <= '0;
      len_q        <= '0;
      res_addr_q   <= '0;
      res_status_q <= ST_DONE;
      out_valid_q  <= 1'b0;
      out_addr_q   <= '0;
      out_status_q <= ST_DONE;
      out_free_q   <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // mark every map word used
        S_CLEAR: begin
          clr_q <= clr_q + MAW'(1);
          if (clr_q == LAST_WORD) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            act_q   <= action_e'(req_i.action);
            start_q <= req_i.phys_address;
            len_q   <= req_i.range_bytes;
            state_q <= S_DECODE;
          end
        end
        // pick the frame range, or finish at once
        S_DECODE: begin
          lim_q        <= lim_c;
          res_addr_q   <= '0;
          res_status_q <= ST_DONE;
          case (act_q)
            ACT_ALLOC: begin
              if (hint_q < lim_c) begin
                lo_q     <= hint_q;
                hi_q     <= lim_c;
                phase2_q <= 1'b0;
                state_q  <= S_DIV;
              end else if (lim_c == '0) begin
                res_status_q <= ST_OOM;
                state_q      <= S_DONE;
              end else begin
                lo_q     <= '0;
                hi_q     <= lim_c;
                phase2_q <= 1'b1;
                state_q  <= S_DIV;
              end
            end
            ACT_FREE: begin
              if (start_q == '0 || s_frame >= lim_ext) begin
                res_status_q <= ST_IGNORED;
                state_q      <= S_DONE;
              end else begin
                lo_q    <= FRW'(s_frame);
                hi_q    <= FRW'(s_frame + EXT_W'(1));
                state_q <= S_DIV;
              end
            end
            ACT_RESERVE: begin
              lo_q <= FRW'(s_frame);
              hi_q <= FRW'(res_fe);
              if (s_frame >= res_fe) begin
                state_q <= S_DONE;
              end else begin
                state_q <= S_DIV;
              end
            end
            default: begin
              lo_q <= FRW'(rel_start);
              hi_q <= FRW'(rel_fe);
              if (rel_start >= rel_fe) begin
                state_q <= S_DONE;
              end else begin
                state_q <= S_DIV;
              end
            end
          endcase
        end
        // first word of the range: multiply by the reciprocal of the word size
        S_DIV: begin
          prod_q  <= PW'(lo_q) * PW'(RECIP);
          state_q <= S_BASE;
        end
        S_BASE: begin
          cur_word_q <= w_c;
          base_q     <= BW'(w_c) * WB_B;
          state_q    <= S_EX;
        end
        // one map word per cycle
        S_EX: begin
          case (act_q)
            ACT_ALLOC: begin
              if (hit) begin
                cnt_q      <= cnt_q - FRW'(1);
                hint_q     <= (fr_next >= BW'(lim_q)) ? '0 : FRW'(fr_next);
                res_addr_q <= ADDR_W'({fr_found, {FRAME_SHIFT{1'b0}}});
                state_q    <= S_DONE;
              end else if (last) begin
                // wrap to the start below the hint, once
                if (phase2_q || hint_q == '0) begin
                  res_status_q <= ST_OOM;
                  state_q      <= S_DONE;
                end else begin
                  lo_q     <= '0;
                  hi_q     <= hint_q;
                  phase2_q <= 1'b1;
                  state_q  <= S_DIV;
                end
              end else begin
                cur_word_q <= cur_word_q + MAW'(1);
                base_q     <= base_q + WB_B;
              end
            end
            ACT_FREE: begin
              if (hit) begin
                cnt_q <= cnt_q + FRW'(1);
                if (lo_q < hint_q) begin
                  hint_q <= lo_q;
                end
              end else begin
                res_status_q <= ST_IGNORED;
              end
              state_q <= S_DONE;
            end
            ACT_RESERVE: begin
              cnt_q <= cnt_q - FRW'(pop);
              if (last) begin
                state_q <= S_DONE;
              end else begin
                cur_word_q <= cur_word_q + MAW'(1);
                base_q     <= base_q + WB_B;
              end
            end
            default: begin
              cnt_q <= cnt_q + FRW'(pop);
              if (last) begin
                state_q <= S_DONE;
              end else begin
                cur_word_q <= cur_word_q + MAW'(1);
                base_q     <= base_q + WB_B;
              end
            end
          endcase
        end
        // hand the result to the output register when it is free
        S_DONE: begin
          if (out_load) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_free_q   <= LIMIT_W'(cnt_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/bitmap_page_frame_allocator_top.sv
// Top level of the bitmap page-frame allocator: frame_limit register, used-map RAM
// and sequencer. Depends on bpfa_pkg, bpfa_if, bpfa_map_ram and bpfa_ctrl.
//
// Keeps one used bit per 4 KB frame, a free count and a next-fit hint, and serves
// one item at a time: allocate, free, reserve range, release range. After reset
// the block runs a clearing pass that marks all MAP_WORDS map words used, one
// word a cycle; req_i.ready stays low meanwhile, while frame_limit writes are
// taken as ever. An accepted item is decoded, the index of its first map word is
// found by a multiply, and that word is read; the map is then walked one word a
// cycle, and last the result is posted. A free visits one map word, reserve and
// release visit each map word the range covers, and allocate scans the words
// from the hint and, when the search wraps, once more from the start; the word
// holding the hint is read in both passes unless the hint is word aligned. An
// empty range, a free of address zero or beyond the limit, and an allocate with
// a zero limit skip the map. The walk runs through the single map read port and
// the shared word unit. The result sits in an output register, so the next item
// is taken while it waits.
`default_nettype none

module bitmap_page_frame_allocator_top #(
  parameter int NUM_FRAMES    = bpfa_pkg::NUM_FRAMES_DEF,
  parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpfa_pkg::LIMIT_W-1:0] cfg_wdata_i,
  bpfa_req_if.sink                          req_i,
  bpfa_rsp_if.source                        rsp_o
);

  import bpfa_pkg::*;

  localparam int MAP_WORDS = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [LIMIT_W-1:0]       limit_q;
  logic                     mem_we;
  logic [MAW-1:0]           mem_waddr, mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata, mem_rdata;

  // frame_limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  bpfa_map_ram #(
    .WB    (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (MAW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bpfa_ctrl #(
    .NUM_FRAMES    (NUM_FRAMES),
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .MAP_WORDS     (MAP_WORDS),
    .MAW           (MAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

`default_nettype wire

### hdl/bpfa_checker.sv
// Port-level checks of the page-frame allocator, bound to its top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_top.
`default_nettype none

module bpfa_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [bpfa_pkg::ADDR_W-1:0]  out_addr_i,
  input  wire logic [1:0]                   out_status_i,
  input  wire logic [bpfa_pkg::LIMIT_W-1:0] out_free_i
);

  import bpfa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable({out_addr_i, out_status_i, out_free_i}))
    else $error("stalled result changed");

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // frame addresses are frame aligned
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_addr_i[FRAME_SHIFT-1:0] == '0)
    else $error("unaligned frame address");

  // no address unless the action completed
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_DONE |-> out_addr_i == '0)
    else $error("address on failed or ignored item");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_addr_i   (rsp_o.frame_address),
  .out_status_i (rsp_o.status),
  .out_free_i   (rsp_o.free_frames)
);

`default_nettype wire
